// ===== src/apde_pkg.sv =====
// ----------------------------------------------------------------------------
// apde_pkg
// shared types and constants of the ack paced delay estimator
// ----------------------------------------------------------------------------
`default_nettype none

package apde_pkg;

    localparam int BAND_W    = 2;
    localparam int ACK_W     = 32;
    localparam int SEG_W     = 16;
    localparam int CREDIT_W  = 31;
    localparam int CFG_IDX_W = 3;
    localparam int RATE_NUM  = 4;

    localparam logic [SEG_W-1:0] SEG_RESET   = 16'd1448;
    localparam logic [ACK_W-1:0] RATE_RESET  = 32'd1;
    localparam logic [ACK_W-1:0] BITS_SCALE  = 32'd8000;
    localparam logic [ACK_W-1:0] US_SCALE    = 32'd1000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BAND0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BAND1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BAND2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BAND3   = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic latch_in;
        logic read_band;
        logic classify;
        logic start_div;
        logic div_sel_rate;
        logic take_part;
        logic scale;
        logic take_delay;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic skip;
        logic partial;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/apde_div.sv =====
// ----------------------------------------------------------------------------
// apde_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module apde_div
    import apde_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [ACK_W-1:0] i_num,
    input  wire logic [ACK_W-1:0] i_den,
    output logic                  o_done,
    output logic [ACK_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(ACK_W);

    logic [ACK_W:0]   r_rem;
    logic [ACK_W-1:0] r_quo;
    logic [ACK_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [ACK_W:0]   n_shift;
    logic [ACK_W:0]   n_diff;
    logic             n_fit;

    // zero divisor always fits, which yields an all ones quotient
    always_comb begin
        n_shift = {r_rem[ACK_W-1:0], r_quo[ACK_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_fit   = (n_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ACK_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_fit ? n_diff : n_shift;
            r_quo <= {r_quo[ACK_W-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== src/apde_ctrl.sv =====
// ----------------------------------------------------------------------------
// apde_ctrl
// sequencer that steps one packet event through the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module apde_ctrl
    import apde_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CLASS,
        S_QWAIT,
        S_SCALE,
        S_RSTART,
        S_RWAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_cmd   n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.latch_in = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                n_cmd.read_band = 1'b1;
                n_state         = S_CLASS;
            end
            S_CLASS: begin
                n_cmd.classify = 1'b1;
                if (i_sts.skip) begin
                    n_state = S_OUT;
                end else if (i_sts.partial) begin
                    n_cmd.start_div = 1'b1;
                    n_state         = S_QWAIT;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_QWAIT: begin
                if (i_sts.div_done) begin
                    n_cmd.take_part = 1'b1;
                    n_state         = S_SCALE;
                end
            end
            S_SCALE: begin
                n_cmd.scale = 1'b1;
                n_state     = S_RSTART;
            end
            S_RSTART: begin
                n_cmd.start_div    = 1'b1;
                n_cmd.div_sel_rate = 1'b1;
                n_state            = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_sts.div_done) begin
                    n_cmd.take_delay = 1'b1;
                    n_state          = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = n_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/apde_dp.sv =====
// ----------------------------------------------------------------------------
// apde_dp
// per band ack state, config registers, credit and delay arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module apde_dp
    import apde_pkg::*;
#(
    parameter int BANDS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ACK_W-1:0]     i_cfg_data,
    input  wire logic [BAND_W-1:0]    i_band,
    input  wire logic                 i_is_tcp,
    input  wire logic                 i_syn_or_fin,
    input  wire logic [ACK_W-1:0]     i_ack_number,
    output logic [ACK_W-1:0]          o_pace_delay_us,
    output logic                      o_delay_updated,
    output logic [CREDIT_W-1:0]       o_credited_bytes
);

    localparam int IDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;

    logic [SEG_W-1:0] r_seg;
    logic [ACK_W-1:0] r_rate [RATE_NUM];
    logic [ACK_W-1:0] r_high [BANDS];
    logic [ACK_W-1:0] r_dup  [BANDS];

    logic [BAND_W-1:0] r_band;
    logic              r_tcp;
    logic              r_sync;
    logic [ACK_W-1:0]  r_ack;
    logic [ACK_W-1:0]  r_m;
    logic [ACK_W-1:0]  r_d;
    logic [ACK_W-1:0]  r_ds;
    logic [ACK_W-1:0]  r_credit;
    logic [ACK_W-1:0]  r_dnew;
    logic [ACK_W-1:0]  r_prod;
    logic [ACK_W-1:0]  r_delay;

    logic [ACK_W-1:0]    r_out_delay;
    logic                r_out_upd;
    logic [CREDIT_W-1:0] r_out_credit;

    logic [IDX_W-1:0] w_idx;
    logic             w_band_ok;
    logic             w_live;
    logic             w_dup_hit;
    logic             w_jump;
    logic             w_part;
    logic [ACK_W-1:0] w_limit;
    logic [ACK_W-1:0] w_raw;
    logic [ACK_W-1:0] w_div_num;
    logic [ACK_W-1:0] w_div_den;
    logic             w_div_done;
    logic [ACK_W-1:0] w_div_quo;

    assign w_idx     = r_band[IDX_W-1:0];
    assign w_band_ok = (3'(r_band) < 3'(BANDS));
    assign w_live    = w_band_ok && r_tcp;

    always_comb begin
        w_limit   = r_m + r_ds;
        w_dup_hit = (r_ack == r_m);
        w_jump    = (r_ack > w_limit);
        w_part    = (r_ack > r_m);
        w_raw     = r_ack - r_ds - r_m;
    end

    assign o_sts.skip     = !w_live || r_sync;
    assign o_sts.partial  = !w_dup_hit && !w_jump && w_part;
    assign o_sts.div_done = w_div_done;

    // one divider shared by the partial advance and the delay
    assign w_div_num = i_cmd.div_sel_rate ? r_prod : (r_ack - r_m);
    assign w_div_den = i_cmd.div_sel_rate ? r_rate[r_band] : {16'b0, r_seg};

    apde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // config registers and per band state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_RESET;
            for (int i = 0; i < RATE_NUM; i++) begin
                r_rate[i] <= RATE_RESET;
            end
            for (int i = 0; i < BANDS; i++) begin
                r_high[i] <= '0;
                r_dup[i]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SEGMENT_SIZE: r_seg     <= i_cfg_data[SEG_W-1:0];
                    CFG_RATE_BAND0:   r_rate[0] <= i_cfg_data;
                    CFG_RATE_BAND1:   r_rate[1] <= i_cfg_data;
                    CFG_RATE_BAND2:   r_rate[2] <= i_cfg_data;
                    CFG_RATE_BAND3:   r_rate[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.commit && w_live) begin
                r_high[w_idx] <= r_ack;
                r_dup[w_idx]  <= r_sync ? '0 : r_dnew;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_band <= i_band;
            r_tcp  <= i_is_tcp;
            r_sync <= i_syn_or_fin;
            r_ack  <= i_ack_number;
        end
        if (i_cmd.read_band) begin
            r_m  <= r_high[w_idx];
            r_d  <= r_dup[w_idx];
            r_ds <= 32'(r_dup[w_idx] * {16'b0, r_seg});
        end
        if (i_cmd.classify) begin
            if (w_dup_hit) begin
                r_credit <= {16'b0, r_seg};
                r_dnew   <= r_d + 1'b1;
            end else if (w_jump) begin
                r_credit <= w_raw[ACK_W-1] ? '0 : w_raw;
                r_dnew   <= '0;
            end else if (w_part) begin
                r_credit <= {16'b0, r_seg};
                r_dnew   <= r_d;
            end else begin
                r_credit <= '0;
                r_dnew   <= r_d;
            end
        end
        if (i_cmd.take_part) begin
            r_dnew <= r_d - (w_div_quo - 1'b1);
        end
        if (i_cmd.scale) begin
            r_prod <= 32'(r_credit * BITS_SCALE);
        end
        if (i_cmd.take_delay) begin
            r_delay <= 32'(w_div_quo * US_SCALE);
        end
        if (i_cmd.commit) begin
            if (o_sts.skip) begin
                r_out_delay  <= '0;
                r_out_upd    <= 1'b0;
                r_out_credit <= '0;
            end else begin
                r_out_delay  <= r_delay;
                r_out_upd    <= 1'b1;
                r_out_credit <= r_credit[CREDIT_W-1:0];
            end
        end
    end

    assign o_pace_delay_us  = r_out_delay;
    assign o_delay_updated  = r_out_upd;
    assign o_credited_bytes = r_out_credit;

endmodule

`default_nettype wire

// ===== src/ack_paced_delay_estimator.sv =====
// ----------------------------------------------------------------------------
// ack_paced_delay_estimator
// per band tcp ack tracking and pacing delay computation
// ----------------------------------------------------------------------------
// Takes one packet event per request and returns exactly one result per
// request. A tcp request without syn/fin updates its band's highest ack and
// duplicate-ack count, credits bytes and returns the pacing delay
// ((8000 * credit) / rate limit of the band) * 1000, all wrapping at 32 bits.
// syn/fin requests resync the band, non-tcp requests and bands at or above
// BANDS leave state alone; those return all zero fields. One request is in
// work at a time. The single shared 32-bit restoring divider yields one
// quotient bit per cycle and runs once for the delay and once more for the
// partial advance. A new request is taken while the previous result is
// still waiting at the output register. Config writes are always accepted
// and must only happen while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ack_paced_delay_estimator
    import apde_pkg::*;
#(
    parameter int BANDS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // config write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ACK_W-1:0]     i_cfg_data,
    // packet event requests
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [BAND_W-1:0]    i_band,
    input  wire logic                 i_is_tcp,
    input  wire logic                 i_syn_or_fin,
    input  wire logic [ACK_W-1:0]     i_ack_number,
    // results
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [ACK_W-1:0]          o_pace_delay_us,
    output logic                      o_delay_updated,
    output logic [CREDIT_W-1:0]       o_credited_bytes
);

    t_cmd w_cmd;
    t_sts w_sts;

    // config registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: accept, read band, classify, partial divide, scale, delay divide, hand off
    apde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // band state, config, arithmetic and the result register
    apde_dp #(
        .BANDS (BANDS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_band           (i_band),
        .i_is_tcp         (i_is_tcp),
        .i_syn_or_fin     (i_syn_or_fin),
        .i_ack_number     (i_ack_number),
        .o_pace_delay_us  (o_pace_delay_us),
        .o_delay_updated  (o_delay_updated),
        .o_credited_bytes (o_credited_bytes)
    );

endmodule

`default_nettype wire
